>>> hw/rtl/key_matrix_debouncer_core_defines.svh
// Assertion macros shared by the key matrix debouncer RTL.
`ifndef KEY_MATRIX_DEBOUNCER_CORE_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define KMD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("kmd assertion failed");
`define KMD_ASSERT_NEVER(label, clk, rst, cond) \
   `KMD_ASSERT(label, clk, rst, !(cond))
`else
`define KMD_ASSERT(label, clk, rst, prop)
`define KMD_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> hw/rtl/kmd_pkg.sv
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;
   localparam int ROW_W      = 3;
   localparam int COL_W      = 10;
   localparam int CNT_W      = 8;
   localparam int CTR_W      = 16;
   localparam int TALLY_W    = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int RSP_DEPTH  = 3;
   localparam int FILL_W     = $clog2(RSP_DEPTH + 1);

   localparam logic [CNT_W-1:0] PRESS_SETTLE_RESET   = 8'd5;
   localparam logic [CNT_W-1:0] RELEASE_SETTLE_RESET = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_SETTLE   = 2'd0,
      CSR_RELEASE_SETTLE = 2'd1
   } csr_index_type;

   // per-row event counts from the column update
   typedef struct packed {
      logic [TALLY_W-1:0] raw_changes;
      logic [TALLY_W-1:0] settles;
      logic [TALLY_W-1:0] phantoms;
   } tally_type;

   typedef struct packed {
      logic [ROW_W-1:0] row_out;
      logic [COL_W-1:0] stable_columns;
      logic [COL_W-1:0] changed_mask;
      logic [CTR_W-1:0] bounce_total;
      logic [CTR_W-1:0] phantom_total;
   } rsp_item_type;
endpackage

>>> hw/rtl/kmd_intf.sv
// Valid/ready channel interfaces for row samples and debounced results.
interface kmd_req_if import kmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_index;
   logic [COL_W-1:0] raw_columns;

   modport source (output valid, row_index, raw_columns, input ready);
   modport sink (input valid, row_index, raw_columns, output ready);
endinterface

interface kmd_rsp_if import kmd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] row_out;
   logic [COL_W-1:0] stable_columns;
   logic [COL_W-1:0] changed_mask;
   logic [CTR_W-1:0] bounce_total;
   logic [CTR_W-1:0] phantom_total;

   modport source (output valid, row_out, stable_columns, changed_mask, bounce_total,
                   phantom_total, input ready);
   modport sink (input valid, row_out, stable_columns, changed_mask, bounce_total,
                 phantom_total, output ready);
endinterface

>>> hw/rtl/kmd_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
module kmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hw/rtl/kmd_row_update.sv
// Per-column debounce update for one row entry.
module kmd_row_update import kmd_pkg::*; #(
   parameter int COLS = 10
) (
   input  logic [COLS-1:0]            raw,
   input  logic [COLS-1:0]            last_raw,
   input  logic [COLS-1:0]            stable,
   input  logic [COLS-1:0][CNT_W-1:0] settle,
   input  logic [CNT_W-1:0]           press_scans,
   input  logic [CNT_W-1:0]           release_scans,
   output logic [COLS-1:0]            next_last_raw,
   output logic [COLS-1:0]            next_stable,
   output logic [COLS-1:0][CNT_W-1:0] next_settle,
   output logic [COLS-1:0]            changed,
   output tally_type                  tally
);
   always_comb begin
      next_last_raw = last_raw;
      next_stable   = stable;
      next_settle   = settle;
      changed       = '0;
      tally         = '0;
      for (int c = 0; c < COLS; c++) begin
         if (raw[c] != last_raw[c]) begin
            next_last_raw[c] = raw[c];
            // reload picks by the debounced level: released (1) uses press time
            next_settle[c] = stable[c] ? press_scans : release_scans;
            tally.raw_changes = tally.raw_changes + TALLY_W'(1);
         end else if (settle[c] != '0) begin
            next_settle[c] = settle[c] - CNT_W'(1);
            if (settle[c] == CNT_W'(1)) begin
               if (stable[c] != last_raw[c]) begin
                  next_stable[c] = last_raw[c];
                  changed[c]     = 1'b1;
                  tally.settles  = tally.settles + TALLY_W'(1);
               end else begin
                  tally.phantoms = tally.phantoms + TALLY_W'(1);
               end
            end
         end
      end
   end
endmodule

>>> hw/rtl/kmd_rsp_fifo.sv
// Result queue: a circular buffer of RSP_DEPTH entries feeding the result channel.
`include "key_matrix_debouncer_core_defines.svh"
module kmd_rsp_fifo import kmd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rsp_item_type      push_item,
   kmd_rsp_if.source         rsp_port,
   output logic [FILL_W-1:0] fill
);
   localparam int PTR_W = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RSP_DEPTH - 1);

   rsp_item_type      slot_ff [RSP_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              pop;
   rsp_item_type      head;

   assign pop  = rsp_port.valid && rsp_port.ready;
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   fill_in = fill_ff + FILL_W'(1);
         2'b01:   fill_in = fill_ff - FILL_W'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_port.valid          = fill_ff != '0;
   assign rsp_port.row_out        = head.row_out;
   assign rsp_port.stable_columns = head.stable_columns;
   assign rsp_port.changed_mask   = head.changed_mask;
   assign rsp_port.bounce_total   = head.bounce_total;
   assign rsp_port.phantom_total  = head.phantom_total;
   assign fill                    = fill_ff;

   `KMD_ASSERT_NEVER(a_no_overflow, clock, reset, push && !pop && fill_ff == FILL_W'(RSP_DEPTH))
   `KMD_ASSERT(a_fill_tracks_push, clock, reset, push && !pop |=> fill_ff == $past(fill_ff) + FILL_W'(1))
endmodule

>>> hw/rtl/key_matrix_debouncer_core.sv
// Key matrix debouncer top level: row-state RAM, update stage and result queue.
`include "key_matrix_debouncer_core_defines.svh"
// Row samples are accepted one per clock while req_port.ready is high and pass the
// update stage into the result queue. Per-row state (last raw level, debounced
// level and an 8-bit settle countdown per key) lives in a RAM of ROW_COUNT entries
// with one read and one write port: the row is read when the sample is accepted
// and written back the next cycle, and a one-deep bypass covers a sample that
// follows the same row directly. Rows start out released with idle countdowns
// through per-row valid flags, so no clearing pass runs after reset. A three-entry
// result queue lets samples keep flowing while a result waits; req_port.ready drops
// when the queued results plus the update stage reach three. Rows at or above
// ROW_COUNT leave the state alone and report all keys released. Settle times must
// be written only while no sample is in flight.
module key_matrix_debouncer_core import kmd_pkg::*; #(
   parameter int ROW_COUNT    = 7,
   parameter int COLUMN_COUNT = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   kmd_req_if.sink               req_port,
   kmd_rsp_if.source             rsp_port,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int ROWS_USED = (ROW_COUNT > (1 << ROW_W)) ? (1 << ROW_W) : ROW_COUNT;
   localparam int COLS      = (COLUMN_COUNT > COL_W) ? COL_W : COLUMN_COUNT;
   localparam int ROW_AW    = (ROWS_USED > 1) ? $clog2(ROWS_USED) : 1;
   localparam int ROW_SLOTS = 1 << ROW_AW;
   localparam int ENTRY_W   = COLS * (2 + CNT_W);
   localparam logic [ROW_W:0]       ROW_LIMIT   = (ROW_W + 1)'(ROWS_USED);
   localparam logic [COLS-1:0]      ALL_COLS    = '1;
   localparam logic [ENTRY_W-1:0]   RESET_ENTRY = {(COLS * CNT_W)'(0), ALL_COLS, ALL_COLS};

   logic [CNT_W-1:0]   press_ff, release_ff;
   logic               req_fire, req_in_range;
   logic [FILL_W-1:0]  rsp_fill;

   logic               s1_valid_ff;
   logic [ROW_W-1:0]   s1_row_ff;
   logic [COLS-1:0]    s1_raw_ff;
   logic               s1_in_range_ff;
   logic [ROW_AW-1:0]  s1_addr;

   logic [ROW_SLOTS-1:0] row_valid_ff;
   logic                 fwd_valid_ff;
   logic [ROW_AW-1:0]    fwd_addr_ff;
   logic [ENTRY_W-1:0]   fwd_data_ff;
   logic                 fwd_hit;

   logic [ENTRY_W-1:0]            ram_rd_data;
   logic [ENTRY_W-1:0]            cur_entry, new_entry;
   logic [COLS-1:0][CNT_W-1:0]    cur_settle, new_settle;
   logic [COLS-1:0]               new_last, new_stable, changed;
   tally_type                     tally;
   logic                          wr_en;

   logic [CTR_W-1:0]   bounce_ff, bounce_in;
   logic [CTR_W-1:0]   phantom_ff, phantom_in;
   rsp_item_type       rsp_item;

   // settle-time registers
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff   <= PRESS_SETTLE_RESET;
         release_ff <= RELEASE_SETTLE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_PRESS_SETTLE) begin
            press_ff <= csr_wr_data;
         end
         if (csr_index == CSR_RELEASE_SETTLE) begin
            release_ff <= csr_wr_data;
         end
      end
   end

   assign req_fire       = req_port.valid && req_port.ready;
   assign req_in_range   = {1'b0, req_port.row_index} < ROW_LIMIT;
   assign req_port.ready = ({1'b0, rsp_fill} + (FILL_W + 1)'(s1_valid_ff))
                           < (FILL_W + 1)'(RSP_DEPTH);

   kmd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROWS_USED)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr),
      .wr_data (new_entry),
      .rd_en   (req_fire && req_in_range),
      .rd_addr (req_port.row_index[ROW_AW-1:0]),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_row_ff      <= req_port.row_index;
         s1_raw_ff      <= req_port.raw_columns[COLS-1:0];
         s1_in_range_ff <= req_in_range;
      end
   end

   assign s1_addr = s1_row_ff[ROW_AW-1:0];
   assign wr_en   = s1_valid_ff && s1_in_range_ff;

   // RAM read returns old data when the previous write hit the same row
   assign fwd_hit = fwd_valid_ff && (fwd_addr_ff == s1_addr);

   always_comb begin
      priority if (fwd_hit) begin
         cur_entry = fwd_data_ff;
      end else if (row_valid_ff[s1_addr]) begin
         cur_entry = ram_rd_data;
      end else begin
         cur_entry = RESET_ENTRY;
      end
   end

   assign cur_settle = cur_entry[ENTRY_W-1:2*COLS];

   kmd_row_update #(
      .COLS (COLS)
   ) u_row_update (
      .raw           (s1_raw_ff),
      .last_raw      (cur_entry[COLS-1:0]),
      .stable        (cur_entry[2*COLS-1:COLS]),
      .settle        (cur_settle),
      .press_scans   (press_ff),
      .release_scans (release_ff),
      .next_last_raw (new_last),
      .next_stable   (new_stable),
      .next_settle   (new_settle),
      .changed       (changed),
      .tally         (tally)
   );

   assign new_entry = {new_settle, new_stable, new_last};

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         fwd_valid_ff <= wr_en;
         if (wr_en) begin
            row_valid_ff[s1_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= s1_addr;
         fwd_data_ff <= new_entry;
      end
   end

   always_comb begin
      bounce_in  = bounce_ff;
      phantom_in = phantom_ff;
      if (wr_en) begin
         bounce_in  = bounce_ff + CTR_W'(tally.raw_changes) - CTR_W'(tally.settles);
         phantom_in = phantom_ff + CTR_W'(tally.phantoms);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounce_ff  <= '0;
         phantom_ff <= '0;
      end else begin
         bounce_ff  <= bounce_in;
         phantom_ff <= phantom_in;
      end
   end

   always_comb begin
      rsp_item.row_out        = s1_row_ff;
      rsp_item.stable_columns = s1_in_range_ff ? COL_W'(new_stable) : COL_W'(ALL_COLS);
      rsp_item.changed_mask   = s1_in_range_ff ? COL_W'(changed) : '0;
      rsp_item.bounce_total   = bounce_in;
      rsp_item.phantom_total  = phantom_in;
   end

   kmd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_item (rsp_item),
      .rsp_port  (rsp_port),
      .fill      (rsp_fill)
   );

   `KMD_ASSERT(a_accept_enters_update, clock, reset, req_fire |=> s1_valid_ff)
   `KMD_ASSERT(a_counters_hold_idle, clock, reset, !wr_en |=> $stable(bounce_ff) && $stable(phantom_ff))
   `KMD_ASSERT(a_same_row_bypass, clock, reset, wr_en && req_fire && req_in_range && req_port.row_index[ROW_AW-1:0] == s1_addr |=> fwd_hit)
endmodule

>>> tb/key_matrix_debouncer_core_tb.sv
// Self-checking testbench for the key matrix debouncer core with its own row-state predictor.
module key_matrix_debouncer_core_tb import kmd_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROW_COUNT    = 7;
   localparam int COLUMN_COUNT = 10;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_STALL   = 60;

   // indexes past the register list, the block must ignore them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef enum {RSP_ALWAYS, RSP_RANDOM, RSP_PATTERN, RSP_MOSTLY} rsp_pace_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] raw;
   } row_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   kmd_req_if req_if ();
   kmd_rsp_if rsp_if ();

   key_matrix_debouncer_core #(
      .ROW_COUNT    (ROW_COUNT),
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if.sink),
      .rsp_port    (rsp_if.source),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [CNT_W-1:0] press_reload;
   logic [CNT_W-1:0] release_reload;
   logic [COL_W-1:0] raw_level [ROW_COUNT];
   logic [COL_W-1:0] debounced [ROW_COUNT];
   logic [CNT_W-1:0] settle_left [ROW_COUNT][COLUMN_COUNT];
   logic [CTR_W-1:0] bounce_count;
   logic [CTR_W-1:0] phantom_count;

   // stimulus state
   row_sample_type   pending_samples [$];
   rsp_item_type     rows_due [$];
   logic [COL_W-1:0] key_target [ROW_COUNT];
   logic [COL_W-1:0] chatter_bits [ROW_COUNT];
   int               chatter_left [ROW_COUNT];
   int               scan_row;

   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           sender_gap_max = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   rsp_pace_type rsp_pace = RSP_ALWAYS;
   int           stall_requests = 0;
   int           stalls_served = 0;
   int           hold_left = 0;
   int           pace_count = 0;
   row_sample_type next_sample;
   row_sample_type taken;
   rsp_item_type   want;

   function automatic rsp_item_type predict_row_scan(row_sample_type s);
      rsp_item_type r;
      r.row_out        = s.row;
      r.stable_columns = '1;
      r.changed_mask   = '0;
      if (s.row < ROW_COUNT) begin
         for (int c = 0; c < COLUMN_COUNT; c++) begin
            if (raw_level[s.row][c] != s.raw[c]) begin
               raw_level[s.row][c]   = s.raw[c];
               settle_left[s.row][c] = debounced[s.row][c] ? press_reload : release_reload;
               bounce_count++;
            end else if (settle_left[s.row][c] != 0) begin
               settle_left[s.row][c]--;
               if (settle_left[s.row][c] == 0) begin
                  if (debounced[s.row][c] != raw_level[s.row][c]) begin
                     debounced[s.row][c] = raw_level[s.row][c];
                     r.changed_mask[c]   = 1'b1;
                     bounce_count--;
                  end else begin
                     phantom_count++;
                  end
               end
            end
         end
         r.stable_columns = debounced[s.row];
      end
      r.bounce_total  = bounce_count;
      r.phantom_total = phantom_count;
      return r;
   endfunction

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      if (idx == CSR_PRESS_SETTLE)
         press_reload = value;
      else if (idx == CSR_RELEASE_SETTLE)
         release_reload = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_sample(int row, logic [COL_W-1:0] raw, int copies = 1);
      row_sample_type s;
      s.row = ROW_W'(row);
      s.raw = raw;
      repeat (copies) pending_samples.push_back(s);
   endtask

   // round-robin scan with occasional key changes that chatter for a few scans,
   // mixed with stray samples on any row including the unused one
   task automatic queue_scan_rounds(int count);
      row_sample_type   s;
      logic [COL_W-1:0] flips;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 8) begin
            s.row = ROW_W'($urandom_range(0, 7));
            s.raw = COL_W'($urandom);
         end else begin
            s.row    = ROW_W'(scan_row);
            scan_row = (scan_row == ROW_COUNT - 1) ? 0 : scan_row + 1;
            if (chatter_left[s.row] != 0) begin
               chatter_left[s.row]--;
               s.raw = key_target[s.row] ^ (COL_W'($urandom) & chatter_bits[s.row]);
            end else begin
               if ($urandom_range(0, 99) < 12) begin
                  flips = $urandom_range(0, 1) ? COL_W'($urandom & $urandom & $urandom)
                                               : COL_W'($urandom);
                  chatter_bits[s.row] = flips;
                  key_target[s.row]   = key_target[s.row] ^ flips;
                  chatter_left[s.row] = $urandom_range(0, 3);
               end
               s.raw = key_target[s.row];
            end
         end
         pending_samples.push_back(s);
      end
   endtask

   task automatic drain();
      while (pending_samples.size() != 0 || req_if.valid || rows_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_pacing(rsp_pace_type pace, int gap_max);
      @(negedge clock);
      rsp_pace       = pace;
      sender_gap_max = gap_max;
   endtask

   // sender: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_if.valid       <= 1'b0;
            req_if.row_index   <= ROW_W'($urandom);
            req_if.raw_columns <= COL_W'($urandom);
         end else if (pending_samples.size() != 0) begin
            next_sample = pending_samples.pop_front();
            req_if.valid       <= 1'b1;
            req_if.row_index   <= next_sample.row;
            req_if.raw_columns <= next_sample.raw;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 16);
               gap_left   = (sender_gap_max == 0) ? 0 : $urandom_range(0, sender_gap_max);
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: per-phase stall pattern plus requested long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         pace_count++;
         if (hold_left == 0 && stalls_served != stall_requests) begin
            hold_left = LONG_STALL;
            stalls_served++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rsp_pace)
               RSP_ALWAYS:  rsp_if.ready <= 1'b1;
               RSP_RANDOM:  rsp_if.ready <= 1'($urandom_range(0, 1));
               RSP_PATTERN: rsp_if.ready <= (pace_count % 5 != 0) && (pace_count % 7 < 5);
               default:     rsp_if.ready <= ($urandom_range(0, 99) < 85);
            endcase
         end
      end
   end

   // monitor: predict on each accepted sample, check each accepted result
   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            taken.row = req_if.row_index;
            taken.raw = req_if.raw_columns;
            rows_due.push_back(predict_row_scan(taken));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (rows_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction, row %0d", rsp_if.row_out);
            end else begin
               want = rows_due.pop_front();
               if (want.row_out !== rsp_if.row_out ||
                   want.stable_columns !== rsp_if.stable_columns ||
                   want.changed_mask !== rsp_if.changed_mask ||
                   want.bounce_total !== rsp_if.bounce_total ||
                   want.phantom_total !== rsp_if.phantom_total) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("exp/got row %0d/%0d stable %h/%h changed %h/%h %0d/%0d %0d/%0d",
                              want.row_out, rsp_if.row_out,
                              want.stable_columns, rsp_if.stable_columns,
                              want.changed_mask, rsp_if.changed_mask,
                              want.bounce_total, rsp_if.bounce_total,
                              want.phantom_total, rsp_if.phantom_total);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.row_index   = '0;
      req_if.raw_columns = '0;
      rsp_if.ready       = 1'b0;
      press_reload   = PRESS_SETTLE_RESET;
      release_reload = RELEASE_SETTLE_RESET;
      bounce_count   = '0;
      phantom_count  = '0;
      scan_row       = 0;
      for (int r = 0; r < ROW_COUNT; r++) begin
         raw_level[r]    = '1;
         debounced[r]    = '1;
         key_target[r]   = '1;
         chatter_bits[r] = '0;
         chatter_left[r] = 0;
         for (int c = 0; c < COLUMN_COUNT; c++)
            settle_left[r][c] = '0;
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed part at the reset settle times
      set_pacing(RSP_ALWAYS, 0);
      push_sample(0, 10'h000);
      push_sample(0, 10'h000, 5);   // press settles on the fifth unchanged scan
      push_sample(6, 10'h3ff);
      push_sample(7, 10'h155);      // row past the matrix
      push_sample(7, 10'h2aa);
      push_sample(0, 10'h3ff);      // release of a pressed row, long reload
      push_sample(3, 10'h2aa);
      push_sample(3, 10'h155);
      push_sample(3, 10'h3ff);
      push_sample(3, 10'h3ff, 5);   // chatter settles back: phantoms
      push_sample(5, 10'h001);
      push_sample(5, 10'h200);
      push_sample(1, 10'h3fe);
      push_sample(2, 10'h000);
      push_sample(4, 10'h3ff);
      push_sample(6, 10'h000);
      drain();

      // shortest settle times, long receiver hold-off mid-phase
      write_csr(CSR_PRESS_SETTLE, 8'd1);
      write_csr(CSR_RELEASE_SETTLE, 8'd1);
      set_pacing(RSP_RANDOM, 6);
      queue_scan_rounds(60);
      repeat (30) @(negedge clock);
      stall_requests++;
      drain();

      // longest settle times on a single row
      write_csr(CSR_PRESS_SETTLE, 8'd255);
      write_csr(CSR_RELEASE_SETTLE, 8'd255);
      set_pacing(RSP_PATTERN, 3);
      push_sample(4, 10'h000, 257);
      push_sample(4, 10'h0f0, 2);
      push_sample(4, 10'h000, 2);
      drain();

      // zero press reload: a press never settles
      write_csr(CSR_PRESS_SETTLE, 8'd0);
      write_csr(CSR_RELEASE_SETTLE, 8'd3);
      set_pacing(RSP_MOSTLY, 8);
      queue_scan_rounds(40);
      drain();

      // zero release reload
      write_csr(CSR_PRESS_SETTLE, 8'd4);
      write_csr(CSR_RELEASE_SETTLE, 8'd0);
      set_pacing(RSP_RANDOM, 0);
      queue_scan_rounds(40);
      drain();

      // writes past the register list must leave the settle times alone
      write_csr(CSR_PRESS_SETTLE, 8'd2);
      write_csr(CSR_RELEASE_SETTLE, 8'd6);
      write_csr(CSR_SPARE_2, 8'h00);
      write_csr(CSR_SPARE_3, 8'hff);
      set_pacing(RSP_PATTERN, 5);
      queue_scan_rounds(60);
      repeat (20) @(negedge clock);
      stall_requests++;
      drain();

      write_csr(CSR_PRESS_SETTLE, CSR_DATA_W'($urandom_range(1, 8)));
      write_csr(CSR_RELEASE_SETTLE, CSR_DATA_W'($urandom_range(1, 12)));
      set_pacing(RSP_MOSTLY, 4);
      queue_scan_rounds(50);
      drain();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && rows_due.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
